[hdl/gsd_pkg.sv]
// constants shared by the steepest-descent drop unit
// letter range, step counter limit, tie lfsr taps and neighbour order
// no dependencies
package gsd_pkg;

   localparam int unsigned STEP_W = 12;
   localparam logic [STEP_W-1:0] STEP_MAX = 12'hFFF;

   localparam logic [7:0] LETTER_A = 8'h41;
   localparam logic [7:0] LETTER_Z = 8'h5A;

   // galois lfsr, x^16 + x^14 + x^13 + x^11 + 1
   localparam logic [15:0] LFSR_TAPS = 16'hB400;
   localparam logic [15:0] LFSR_RESET = 16'h0001;

   // neighbour order
   localparam logic [1:0] DIR_SOUTH = 2'd0;
   localparam logic [1:0] DIR_EAST  = 2'd1;
   localparam logic [1:0] DIR_NORTH = 2'd2;
   localparam logic [1:0] DIR_WEST  = 2'd3;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_DROP = 1'b1;

endpackage

[hdl/grid_steepest_descent_drop_unit.sv]
// Sequencing: a load item is written in the idle state. A drop item reads its start cell in the
// start read and start evaluate states, then for each descent step reads and evaluates every
// in-grid neighbour, skips each one off the grid, and decides; the pace is set by the single
// read port shared by the height and occupancy memories. One item at a time.
// Reset: synchronous. After reset the occupancy memory is cleared, one cell a cycle, over all
// GRID_W * GRID_H cells; no item is accepted meanwhile. The lfsr returns to 1.
module grid_steepest_descent_drop_unit
   import gsd_pkg::*;
#(
   parameter int GRID_W = 64,
   parameter int GRID_H = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // x_pos, y_pos, height, letter, zero fill
   input  logic        req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // final_x, final_y, step_count
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);

   localparam int CELLS = GRID_W * GRID_H;
   localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int XW = ($clog2(GRID_W) > 6) ? $clog2(GRID_W) : 6;
   localparam int YW = ($clog2(GRID_H) > 6) ? $clog2(GRID_H) : 6;

   localparam logic [2:0] ST_CLEAR    = 3'd0;
   localparam logic [2:0] ST_IDLE     = 3'd1;
   localparam logic [2:0] ST_START_RD = 3'd2;
   localparam logic [2:0] ST_START_EV = 3'd3;
   localparam logic [2:0] ST_NB_RD    = 3'd4;
   localparam logic [2:0] ST_NB_EV    = 3'd5;
   localparam logic [2:0] ST_DECIDE   = 3'd6;
   localparam logic [2:0] ST_OOB      = 3'd7;

   function automatic logic [AW-1:0] cell_addr(input logic [XW-1:0] cx,
                                               input logic [YW-1:0] cy);
      logic [31:0] lin;
      lin = 32'(cy) * 32'(GRID_W) + 32'(cx);
      return lin[AW-1:0];
   endfunction

   // input fields
   logic [5:0]         in_x;
   logic [5:0]         in_y;
   logic [15:0]        in_height;
   logic [7:0]         in_letter;
   logic               in_bounds;

   // sequencer state
   logic [2:0]         state_ff, state_in;
   logic [XW-1:0]      x_ff, x_in, bx_ff, bx_in;
   logic [YW-1:0]      y_ff, y_in, by_ff, by_in;
   logic signed [15:0] cur_h_ff, cur_h_in, best_h_ff, best_h_in;
   logic [1:0]         dir_ff, dir_in;
   logic [STEP_W-1:0]  steps_ff, steps_in;
   logic [7:0]         letter_ff, letter_in;
   logic [15:0]        lfsr_ff, lfsr_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [23:0]        rsp_data_ff, rsp_data_in;

   // memories
   logic [15:0]        height_mem [CELLS];
   logic               occ_mem [CELLS];
   logic signed [15:0] h_rdata_ff;
   logic               occ_rdata_ff;
   logic [AW-1:0]      rd_addr;
   logic               h_we;
   logic [AW-1:0]      h_waddr;
   logic               o_we;
   logic [AW-1:0]      o_waddr;
   logic               o_wdata;

   // neighbour under test
   logic [XW-1:0]      nx;
   logic [YW-1:0]      ny;
   logic               nb_inside;
   logic               take;
   logic               draw;
   logic               move;
   logic               rsp_free;
   logic               is_letter;
   logic               accept;

   assign in_x      = req_tdata[5:0];
   assign in_y      = req_tdata[11:6];
   assign in_height = req_tdata[27:12];
   assign in_letter = req_tdata[35:28];
   assign in_bounds = (32'(in_x) < 32'(GRID_W)) && (32'(in_y) < 32'(GRID_H));

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign is_letter  = (letter_ff >= LETTER_A) && (letter_ff <= LETTER_Z);
   assign move       = best_h_ff < cur_h_ff;

   always_comb begin
      unique case (dir_ff)
         DIR_SOUTH: begin
            nx = x_ff;
            ny = y_ff + YW'(1);
            nb_inside = (y_ff != YW'(GRID_H - 1));
         end
         DIR_EAST: begin
            nx = x_ff + XW'(1);
            ny = y_ff;
            nb_inside = (x_ff != XW'(GRID_W - 1));
         end
         DIR_NORTH: begin
            nx = x_ff;
            ny = y_ff - YW'(1);
            nb_inside = (y_ff != '0);
         end
         DIR_WEST: begin
            nx = x_ff - XW'(1);
            ny = y_ff;
            nb_inside = (x_ff != '0);
         end
         default: begin
            nx = x_ff;
            ny = y_ff;
            nb_inside = 1'b0;
         end
      endcase
   end

   always_comb begin
      take = 1'b0;
      draw = 1'b0;
      if (state_ff == ST_NB_EV && !occ_rdata_ff) begin
         if (h_rdata_ff < best_h_ff) begin
            take = 1'b1;
         end else if (dir_ff != DIR_SOUTH && h_rdata_ff == best_h_ff) begin
            // a tie draws one bit from the lfsr
            draw = 1'b1;
            take = lfsr_ff[0];
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      bx_in        = bx_ff;
      by_in        = by_ff;
      cur_h_in     = cur_h_ff;
      best_h_in    = best_h_ff;
      dir_in       = dir_ff;
      steps_in     = steps_ff;
      letter_in    = letter_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rd_addr      = (state_ff == ST_START_RD) ? cell_addr(x_ff, y_ff) : cell_addr(nx, ny);
      h_we         = 1'b0;
      h_waddr      = cell_addr(XW'(in_x), YW'(in_y));
      o_we         = 1'b0;
      o_waddr      = cell_addr(x_ff, y_ff);
      o_wdata      = 1'b0;

      if (csr_we) begin
         lfsr_in = csr_wdata;
      end else if (draw) begin
         lfsr_in = (lfsr_ff >> 1) ^ (lfsr_ff[0] ? LFSR_TAPS : 16'h0000);
      end else begin
         lfsr_in = lfsr_ff;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            o_we    = 1'b1;
            o_waddr = clr_ff;
            clr_in  = clr_ff + AW'(1);
            if (clr_ff == AW'(CELLS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser == KIND_LOAD) begin
                  h_we = in_bounds;
               end else begin
                  x_in      = XW'(in_x);
                  y_in      = YW'(in_y);
                  letter_in = in_letter;
                  steps_in  = '0;
                  state_in  = in_bounds ? ST_START_RD : ST_OOB;
               end
            end
         end
         ST_START_RD: begin
            state_in = ST_START_EV;
         end
         ST_START_EV: begin
            cur_h_in  = h_rdata_ff;
            best_h_in = h_rdata_ff;
            bx_in     = x_ff;
            by_in     = y_ff;
            dir_in    = DIR_SOUTH;
            state_in  = ST_NB_RD;
         end
         ST_NB_RD: begin
            if (nb_inside) begin
               state_in = ST_NB_EV;
            end else if (dir_ff == DIR_WEST) begin
               state_in = ST_DECIDE;
            end else begin
               dir_in = dir_ff + 2'd1;
            end
         end
         ST_NB_EV: begin
            if (take) begin
               bx_in     = nx;
               by_in     = ny;
               best_h_in = h_rdata_ff;
            end
            if (dir_ff == DIR_WEST) begin
               state_in = ST_DECIDE;
            end else begin
               dir_in   = dir_ff + 2'd1;
               state_in = ST_NB_RD;
            end
         end
         ST_DECIDE: begin
            if (move) begin
               // leave the current cell; best cell becomes the new current one
               o_we     = 1'b1;
               o_wdata  = 1'b0;
               x_in     = bx_ff;
               y_in     = by_ff;
               cur_h_in = best_h_ff;
               dir_in   = DIR_SOUTH;
               if (steps_ff != STEP_MAX) begin
                  steps_in = steps_ff + STEP_W'(1);
               end
               state_in = ST_NB_RD;
            end else if (rsp_free) begin
               o_we         = 1'b1;
               o_wdata      = is_letter;
               rsp_valid_in = 1'b1;
               rsp_data_in  = {steps_ff, 6'(y_ff), 6'(x_ff)};
               state_in     = ST_IDLE;
            end
         end
         ST_OOB: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {steps_ff, 6'(y_ff), 6'(x_ff)};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (h_we) begin
         height_mem[h_waddr] <= in_height;
      end
      h_rdata_ff <= height_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (o_we) begin
         occ_mem[o_waddr] <= o_wdata;
      end
      occ_rdata_ff <= occ_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         lfsr_ff      <= LFSR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         lfsr_ff      <= lfsr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      y_ff        <= y_in;
      bx_ff       <= bx_in;
      by_ff       <= by_in;
      cur_h_ff    <= cur_h_in;
      best_h_ff   <= best_h_in;
      dir_ff      <= dir_in;
      steps_ff    <= steps_in;
      letter_ff   <= letter_in;
      rsp_data_ff <= rsp_data_in;
   end

   // a new result only comes out of the decide or off-grid states
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DECIDE || $past(state_ff) == ST_OOB))
      else $error("result raised outside a finishing state");

   // a move always lands on a different cell
   a_move_changes_cell: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE && move) |=> (x_ff != $past(x_ff) || y_ff != $past(y_ff)))
      else $error("descent move did not change position");

   // the lfsr only advances on a tie draw or a seed write
   a_lfsr_hold: assert property (@(posedge clock) disable iff (reset)
      (!csr_we && !draw) |=> $stable(lfsr_ff))
      else $error("lfsr changed without a tie draw");

   // no item is taken during the clearing pass
   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR && clr_ff != AW'(CELLS - 1)) |=> !req_tready)
      else $error("input ready during occupancy clear");

endmodule

[tb/sv/tb.sv]
// self-checking testbench for grid_steepest_descent_drop_unit: random terrain, drops and seeds
// holds its own copy of the height grid, occupancy map and tie lfsr to predict each landing
// depends on gsd_pkg and the unit itself
`timescale 1ns / 100ps

typedef struct packed {
   logic [11:0] steps;
   logic [5:0]  y;
   logic [5:0]  x;
} landing_type;

class descent_scoreboard;
   localparam int GRID_W = 64;
   localparam int GRID_H = 64;

   shortint     heights [GRID_W*GRID_H];
   bit          loaded [GRID_W*GRID_H];
   bit          occupied [GRID_W*GRID_H];
   logic [15:0] tie_lfsr;
   landing_type landings_due [$];
   int          fails;

   function new();
      foreach (loaded[i]) begin
         loaded[i] = 1'b0;
         occupied[i] = 1'b0;
         heights[i] = 0;
      end
      tie_lfsr = gsd_pkg::LFSR_RESET;
      fails = 0;
   endfunction

   function void load_seed(logic [15:0] seed);
      tie_lfsr = seed;
   endfunction

   function int pending();
      return landings_due.size();
   endfunction

   task report(string what);
      $display("ERROR at %0t: %s", $realtime, what);
      fails++;
   endtask

   // walks the descent; with commit clear it touches no state and gives the first
   // cell the walk would read before it was loaded, or -1
   function landing_type descend(input int sx, input int sy, input logic [7:0] letter,
                                 input bit commit, output int missing);
      int          x, y, bx, by, nx, ny, n, d;
      logic [1:0]  dir;
      logic [15:0] rng;
      logic [11:0] steps;
      bit          take, tie;
      landing_type res;
      x = sx;
      y = sy;
      rng = tie_lfsr;
      steps = '0;
      missing = -1;
      res = '0;
      if (!loaded[y*GRID_W + x]) begin
         missing = y*GRID_W + x;
         return res;
      end
      forever begin
         bx = x;
         by = y;
         for (d = 0; d < 4; d++) begin
            dir = d[1:0];
            nx = x;
            ny = y;
            case (dir)
               gsd_pkg::DIR_SOUTH: ny = y + 1;
               gsd_pkg::DIR_EAST:  nx = x + 1;
               gsd_pkg::DIR_NORTH: ny = y - 1;
               default:            nx = x - 1;
            endcase
            if (nx < 0 || ny < 0 || nx >= GRID_W || ny >= GRID_H) continue;
            n = ny*GRID_W + nx;
            if (occupied[n]) continue;
            if (!loaded[n]) begin
               missing = n;
               return res;
            end
            take = heights[n] < heights[by*GRID_W + bx];
            // south never wins a tie, the others draw a bit per tie
            if (!take && dir != gsd_pkg::DIR_SOUTH && heights[n] == heights[by*GRID_W + bx]) begin
               tie = rng[0];
               rng = rng >> 1;
               if (tie) rng = rng ^ gsd_pkg::LFSR_TAPS;
               take = tie;
            end
            if (take) begin
               bx = nx;
               by = ny;
            end
         end
         if (!(heights[by*GRID_W + bx] < heights[y*GRID_W + x])) break;
         if (commit) occupied[y*GRID_W + x] = 1'b0;
         x = bx;
         y = by;
         if (steps != gsd_pkg::STEP_MAX) steps++;
      end
      if (commit) begin
         occupied[y*GRID_W + x] = (letter >= gsd_pkg::LETTER_A && letter <= gsd_pkg::LETTER_Z);
         tie_lfsr = rng;
      end
      res.x = x[5:0];
      res.y = y[5:0];
      res.steps = steps;
      return res;
   endfunction

   function void note_item(logic kind, logic [5:0] x, logic [5:0] y, shortint h,
                           logic [7:0] letter);
      int missing;
      if (kind == gsd_pkg::KIND_LOAD) begin
         heights[y*GRID_W + x] = h;
         loaded[y*GRID_W + x] = 1'b1;
      end else begin
         landings_due.push_back(descend(x, y, letter, 1'b1, missing));
      end
   endfunction

   task check_result(logic [23:0] data);
      landing_type got, want;
      got = data;
      if (landings_due.size() == 0) begin
         report($sformatf("landing (%0d,%0d) steps %0d with none expected",
                          got.x, got.y, got.steps));
      end else begin
         want = landings_due.pop_front();
         if (got.x != want.x)
            report($sformatf("final_x %0d, expected %0d", got.x, want.x));
         if (got.y != want.y)
            report($sformatf("final_y %0d, expected %0d", got.y, want.y));
         if (got.steps != want.steps)
            report($sformatf("step_count %0d, expected %0d", got.steps, want.steps));
      end
   endtask
endclass

module tb;
   import gsd_pkg::*;

   localparam int GRID_W = 64;
   localparam int RANDOM_ITEMS = 800;

   typedef enum int {TERRAIN_WALL, TERRAIN_BUMPY, TERRAIN_WIDE, TERRAIN_SLOPE} terrain_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // x_pos, y_pos, height, letter, zero fill
   logic        req_tuser = 1'b0; // kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // final_x, final_y, step_count
   logic        csr_we = 1'b0;
   logic [15:0] csr_wdata = '0;

   descent_scoreboard sb = new();
   terrain_type terrain = TERRAIN_WALL;
   int       slope_x, slope_y;
   int       items_sent = 0;
   bit       steady = 1'b0;

   grid_steepest_descent_drop_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic shortint pick_height(int x, int y);
      int v;
      case (terrain)
         TERRAIN_WALL:  v = 32767;
         TERRAIN_BUMPY: v = $urandom_range(0, 4) - 2;
         TERRAIN_SLOPE: v = -(slope_x*x + slope_y*y) + $urandom_range(0, 2);
         default: begin
            case ($urandom_range(0, 3))
               0:       v = -32768;
               1:       v = 32767;
               default: v = $signed($urandom() % 65536) - 32768;
            endcase
         end
      endcase
      return shortint'(v);
   endfunction

   task automatic send_item(logic kind, int x, int y, shortint h, logic [7:0] letter);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 16);
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {4'b0, letter, h, y[5:0], x[5:0]};
      do @(posedge clock); while (!req_tready);
      sb.note_item(kind, x[5:0], y[5:0], h, letter);
      items_sent++;
   endtask

   task automatic load_cell(int x, int y, shortint h);
      send_item(KIND_LOAD, x, y, h, 8'($urandom_range(0, 255)));
   endtask

   // loads whatever cells the walk would read first, so no unloaded height is ever read
   task automatic drop_at(int x, int y, logic [7:0] letter);
      int missing;
      forever begin
         void'(sb.descend(x, y, letter, 1'b0, missing));
         if (missing < 0) break;
         load_cell(missing % GRID_W, missing / GRID_W,
                   pick_height(missing % GRID_W, missing / GRID_W));
      end
      send_item(KIND_DROP, x, y, shortint'($urandom()), letter);
   endtask

   task automatic write_seed(logic [15:0] seed);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      // a trailing load may still be in flight
      repeat (8) @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= seed;
      @(negedge clock);
      csr_we <= 1'b0;
      sb.load_seed(seed);
   endtask

   // result side
   initial begin
      int stall;
      forever begin
         stall = steady ? 0 : $urandom_range(0, 16);
         repeat (stall) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
         end
         @(negedge clock);
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_result(rsp_tdata);
      end
   end

   initial begin
      #200_000_000;
      $display("grid_steepest_descent_drop_unit: mismatch");
      $finish;
   end

   initial begin
      int phase, w, h, x0, y0, ops, pick;
      logic [15:0] seed;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extreme heights, ties, letters at the edges of A..Z, both corners
      terrain = TERRAIN_WALL;
      load_cell(0, 0, 16'sh7FFF);
      load_cell(1, 0, -16'sh8000);
      load_cell(0, 1, -16'sh8000);
      load_cell(1, 1, -16'sh8000);
      drop_at(0, 0, LETTER_A);
      drop_at(0, 0, LETTER_Z);
      drop_at(0, 0, LETTER_A - 8'd1);
      drop_at(1, 1, LETTER_Z + 8'd1);
      drop_at(1, 1, 8'h00);
      drop_at(1, 1, 8'hFF);
      load_cell(63, 63, 0);
      load_cell(62, 63, 0);
      load_cell(63, 62, -1);
      drop_at(63, 63, 8'h4D);
      // south level with the start is never taken, the east tie may be, but no drop moves
      load_cell(32, 32, 5);
      load_cell(32, 33, 5);
      load_cell(33, 32, 5);
      drop_at(32, 32, LETTER_A);
      drop_at(32, 32, 8'h61);

      phase = 0;
      while (items_sent < RANDOM_ITEMS) begin
         phase++;
         case (phase)
            1:       seed = 16'h0000;
            2:       seed = 16'hFFFF;
            3:       seed = 16'h8000;
            4:       seed = LFSR_RESET;
            default: seed = 16'($urandom_range(1, 65535));
         endcase
         write_seed(seed);
         steady = ($urandom_range(0, 3) == 0);
         terrain = terrain_type'($urandom_range(1, 3));
         slope_x = $urandom_range(0, 8) - 4;
         slope_y = $urandom_range(0, 8) - 4;
         w = $urandom_range(2, 8);
         h = $urandom_range(2, 8);
         x0 = $urandom_range(0, GRID_W - w);
         y0 = $urandom_range(0, GRID_W - h);
         for (int yy = y0; yy < y0 + h; yy++)
            for (int xx = x0; xx < x0 + w; xx++)
               load_cell(xx, yy, pick_height(xx, yy));
         ops = $urandom_range(30, 70);
         repeat (ops) begin
            if (items_sent >= RANDOM_ITEMS) break;
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
               drop_at(x0 + $urandom_range(0, w - 1), y0 + $urandom_range(0, h - 1),
                       $urandom_range(0, 1) ? 8'(LETTER_A + $urandom_range(0, 25))
                                            : 8'($urandom_range(0, 255)));
            end else if (pick < 95) begin
               x0 = x0;
               load_cell(x0 + $urandom_range(0, w - 1), y0 + $urandom_range(0, h - 1),
                         pick_height(x0, y0));
            end else begin
               load_cell($urandom_range(0, 63), $urandom_range(0, 63), shortint'($urandom()));
            end
         end
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      for (int i = 0; i < 100000 && sb.pending() != 0; i++) @(posedge clock);
      repeat (50) @(posedge clock);
      if (sb.pending() != 0)
         sb.report($sformatf("%0d landings never arrived", sb.pending()));
      if (sb.fails == 0) begin
         $display("grid_steepest_descent_drop_unit: match");
      end else begin
         $display("grid_steepest_descent_drop_unit: mismatch");
      end
      $finish;
   end

endmodule
